/* src/erl_pkg.sv */
package erl_pkg;

  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned ADDR_W      = 8;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned TEXT_W      = 16;
  localparam int unsigned ENTRY_W     = TIME_W + 2 * TEXT_W;

  localparam logic [7:0]  DIGIT_ZERO  = 8'h30;
  localparam logic [7:0]  SPEED_MAX   = 8'd99;
  localparam int unsigned ADDR_STRIDE = 10;
  localparam logic [1:0]  HOUR_TENS_MASK = 2'h3;
  localparam logic [2:0]  MS_TENS_MASK   = 3'h7;
  localparam logic [3:0]  UNITS_MASK     = 4'hF;

  typedef enum logic [1:0] {
    ACT_LOG   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_LOGGED     = 2'd0,
    ST_CLEARED    = 2'd1,
    ST_READ_VALID = 2'd2,
    ST_READ_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  hour_bcd;
    logic [7:0]  minute_bcd;
    logic [7:0]  second_bcd;
    logic [15:0] event_code;
    logic [7:0]  speed;
    logic [3:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   storage_address;
    logic [TIME_W-1:0]   time_text;
    logic [TEXT_W-1:0]   event_text;
    logic [TEXT_W-1:0]   speed_text;
    logic [COUNT_W-1:0]  record_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // take the incoming item and launch the slot read
    logic commit;   // update state and load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_drop;  // incoming item carries the unused action code
  } dp_sts_t;

endpackage

/* src/erl_ctrl.sv */
module erl_ctrl
  import erl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        // drop items with the unused code on acceptance
        if (in_valid_i && !sts_i.in_drop) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/erl_dp.sv */
module erl_dp
  import erl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH    = 10,
  parameter int unsigned ADDRESS_BASE = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_item_t out_item_o
);

  localparam int unsigned IDX_W = $clog2(LOG_DEPTH);
  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);

  logic [ENTRY_W-1:0] mem_q [LOG_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  in_item_t           item_q;
  logic [IDX_W-1:0]   wpos_q, wpos_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  out_item_t          out_q, out_d;

  logic [TIME_W-1:0]  fmt_time;
  logic [TEXT_W-1:0]  fmt_speed;
  logic [6:0]         speed_sat;
  logic [14:0]        tens_prod;
  logic [3:0]         speed_tens;
  logic [3:0]         speed_units;
  logic               read_hit;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
    logic [ADDR_W-1:0] s_ext;
    s_ext = ADDR_W'(s);
    return ADDR_W'(s_ext * ADDR_W'(ADDR_STRIDE) + ADDR_W'(ADDRESS_BASE));
  endfunction

  assign sts_o.in_drop = (in_item_i.action == ACT_NONE);

  // ASCII formatting of the captured item
  assign fmt_time = {
    DIGIT_ZERO + {6'd0, item_q.hour_bcd[5:4] & HOUR_TENS_MASK},
    DIGIT_ZERO + {4'd0, item_q.hour_bcd[3:0] & UNITS_MASK},
    DIGIT_ZERO + {5'd0, item_q.minute_bcd[6:4] & MS_TENS_MASK},
    DIGIT_ZERO + {4'd0, item_q.minute_bcd[3:0] & UNITS_MASK},
    DIGIT_ZERO + {5'd0, item_q.second_bcd[6:4] & MS_TENS_MASK},
    DIGIT_ZERO + {4'd0, item_q.second_bcd[3:0] & UNITS_MASK}
  };

  // divide by ten via reciprocal, exact below one hundred
  assign speed_sat   = (item_q.speed > SPEED_MAX) ? SPEED_MAX[6:0] : item_q.speed[6:0];
  assign tens_prod   = 15'(speed_sat) * 15'd205;
  assign speed_tens  = tens_prod[14:11];
  assign speed_units = 4'(speed_sat - 7'(speed_tens) * 7'd10);
  assign fmt_speed   = {DIGIT_ZERO + {4'd0, speed_tens}, DIGIT_ZERO + {4'd0, speed_units}};

  assign read_hit = (32'(item_q.read_slot) < 32'(cnt_q));

  always_comb begin
    wpos_d = wpos_q;
    cnt_d  = cnt_q;
    out_d  = '0;
    case (item_q.action)
      ACT_LOG: begin
        wpos_d = (wpos_q == IDX_W'(LOG_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
        if (cnt_q != CNT_W'(LOG_DEPTH)) begin
          cnt_d = cnt_q + 1'b1;
        end
        out_d.status          = ST_LOGGED;
        out_d.slot            = SLOT_W'(wpos_q);
        out_d.storage_address = slot_addr(SLOT_W'(wpos_q));
        out_d.time_text       = fmt_time;
        out_d.event_text      = item_q.event_code;
        out_d.speed_text      = fmt_speed;
        out_d.record_count    = COUNT_W'(cnt_d);
      end
      ACT_CLEAR: begin
        wpos_d       = '0;
        cnt_d        = '0;
        out_d.status = ST_CLEARED;
      end
      ACT_READ: begin
        out_d.slot            = item_q.read_slot;
        out_d.storage_address = slot_addr(item_q.read_slot);
        out_d.record_count    = COUNT_W'(cnt_q);
        if (read_hit) begin
          out_d.status     = ST_READ_VALID;
          out_d.time_text  = rd_q[ENTRY_W-1 -: TIME_W];
          out_d.event_text = rd_q[2*TEXT_W-1 -: TEXT_W];
          out_d.speed_text = rd_q[TEXT_W-1:0];
        end else begin
          out_d.status = ST_READ_EMPTY;
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      wpos_q <= wpos_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
      rd_q   <= mem_q[in_item_i.read_slot[IDX_W-1:0]];
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
      if (item_q.action == ACT_LOG) begin
        mem_q[wpos_q] <= {fmt_time, item_q.event_code, fmt_speed};
      end
    end
  end

  assign out_item_o = out_q;

endmodule

/* src/event_record_ring_logger_unit.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_item_i  (in_item_t)
// out       output     out_valid_o/out_ready_i out_item_o (out_item_t)
//
// Acceptance launches the slot read; the execute step then formats the record,
// writes the ring slot for a log item and loads the result register.
// Reset clears the write position and record count; slot contents stay unset.
// A result waiting on out_ready_i does not block acceptance of the next item;
// the second item holds in execution until the result register frees up.
// Items with the unused action code are accepted and dropped.
module event_record_ring_logger_unit
  import erl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH    = 10,
  parameter int unsigned ADDRESS_BASE = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing: accept, execute, hand over
  erl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // formatting, ring storage, position and count
  erl_dp #(
    .LOG_DEPTH    (LOG_DEPTH),
    .ADDRESS_BASE (ADDRESS_BASE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule
